@@ design/lru_dirty_set_limiter_top_assert.svh @@
// assertion macros for the lru dirty-set limiter
// expects i_clk and i_rst_n in the scope of the module that includes it
`ifndef LRU_DIRTY_SET_LIMITER_TOP_ASSERT_SVH
`define LRU_DIRTY_SET_LIMITER_TOP_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define LDS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence that holds in the cycle after the antecedent
`define LDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lds_pkg.sv @@
// shared constants and types for the lru dirty-set limiter
// no dependencies; imported by lru_dirty_set_limiter_top and its testbench
package lds_pkg;

    localparam int PAGES        = 16384;
    localparam int PAGE_W       = $clog2(PAGES);
    localparam int CNT_W        = $clog2(PAGES + 1);
    localparam int FIELD_W      = 15;
    localparam int PAGE_FIELD_W = 14;
    localparam int CMP_W        = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 48;
    localparam int APB_ADDR_W   = 2;
    localparam int APB_DATA_W   = 32;

    localparam logic [FIELD_W-1:0]    TARGET_RESET = FIELD_W'(16384);
    localparam logic [APB_ADDR_W-1:0] REG_TARGET   = APB_ADDR_W'(0);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EPOCH = 1'b1;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_CHK  = 5'b00100,
        S_MOVE = 5'b01000,
        S_EV   = 5'b10000
    } t_state;

endpackage

@@ design/lru_dirty_set_limiter_top.sv @@
// lru dirty-set limiter top: a write access runs S_CHK alone (clean or newest page), and
// S_MOVE after it to move a dirty page; an epoch end runs S_EV, one eviction per cycle along
// the newer links; one item in flight at a time; a held report stalls only the next epoch end
// reset: synchronous; a clearing pass over all PAGES (16384) pages zeroes the dirty flags,
// input not taken meanwhile, configuration writes still accepted
// uses lds_pkg and lru_dirty_set_limiter_top_assert.svh
module lru_dirty_set_limiter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lds_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [13:0] page, rest zero
    input  logic [0:0]                       s_axis_tuser,  // [0] command
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lds_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [14:0] dirty_before,
                                                            // [29:15] evicted_count,
                                                            // [44:30] dirty_after
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lds_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lds_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lds_pkg::*;

    `include "lru_dirty_set_limiter_top_assert.svh"

    // page memory holds the dirty flag and the older link of each page,
    // newer memory the newer link; one write and one read port each
    logic [PAGE_W:0]   page_mem  [PAGES];  // [PAGE_W] dirty, [PAGE_W-1:0] older link
    logic [PAGE_W-1:0] newer_mem [PAGES];

    logic              page_we, page_wdirty;
    logic [PAGE_W-1:0] page_waddr, page_wolder, page_raddr;
    logic              newer_we;
    logic [PAGE_W-1:0] newer_waddr, newer_wdata, newer_raddr;

    logic              r_dirty_rd;
    logic [PAGE_W-1:0] r_older_rd, r_newer_rd;

    // control and recency state
    t_state             r_state, n_state;
    logic [PAGE_W-1:0]  r_clr_addr, n_clr_addr;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [PAGE_W-1:0]  r_oldest, n_oldest;
    logic [PAGE_W-1:0]  r_newest, n_newest;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_before, n_before;
    logic [CNT_W-1:0]   r_evicted, n_evicted;
    logic [FIELD_W-1:0] r_target, n_target;

    // result register
    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_o_before, n_o_before;
    logic [FIELD_W-1:0] r_o_evicted, n_o_evicted;
    logic [FIELD_W-1:0] r_o_after, n_o_after;

    logic [PAGE_W-1:0]  in_page;
    logic               in_range;
    logic               in_xfer;
    logic               out_free;
    logic               over_target;
    logic               cfg_write;
    logic               evict_now;
    logic [CNT_W-1:0]   count_dec;
    logic [FIELD_W-1:0] o_sum;

    assign in_page     = PAGE_W'(s_axis_tdata[PAGE_FIELD_W-1:0]);
    assign in_range    = CMP_W'(s_axis_tdata[PAGE_FIELD_W-1:0]) < CMP_W'(PAGES);
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign out_free    = !r_out_valid || m_axis_tready;
    assign over_target = CMP_W'(r_count) > CMP_W'(r_target);
    assign cfg_write   = psel && penable && pwrite && pready && (paddr == REG_TARGET);
    assign evict_now   = (r_state == S_EV) && over_target;
    assign count_dec   = r_count - CNT_W'(1);
    assign o_sum       = FIELD_W'(r_o_after + r_o_evicted);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - 3 * FIELD_W)'(0), r_o_after, r_o_evicted, r_o_before};
    assign pready        = 1'b1;
    assign prdata        = (paddr == REG_TARGET) ? APB_DATA_W'(r_target) : '0;

    // memories: registered read, write lands at the same edge
    always_ff @(posedge i_clk) begin
        if (page_we) begin
            page_mem[page_waddr] <= {page_wdirty, page_wolder};
        end
        {r_dirty_rd, r_older_rd} <= page_mem[page_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (newer_we) begin
            newer_mem[newer_waddr] <= newer_wdata;
        end
        r_newer_rd <= newer_mem[newer_raddr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_page      = r_page;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_count     = r_count;
        n_before    = r_before;
        n_evicted   = r_evicted;
        n_target    = cfg_write ? pwdata[FIELD_W-1:0] : r_target;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_o_before  = r_o_before;
        n_o_evicted = r_o_evicted;
        n_o_after   = r_o_after;

        page_we     = 1'b0;
        page_waddr  = r_page;
        page_wdirty = 1'b1;
        page_wolder = r_newest;
        newer_we    = 1'b0;
        newer_waddr = r_newest;
        newer_wdata = r_page;

        // reads default to the incoming page; an epoch end starts at the oldest page
        page_raddr  = in_page;
        newer_raddr = (s_axis_tuser[0] == CMD_EPOCH) ? r_oldest : in_page;

        unique case (r_state)
            S_CLR: begin
                // clearing pass over the dirty flags after reset
                page_we     = 1'b1;
                page_waddr  = r_clr_addr;
                page_wdirty = 1'b0;
                page_wolder = '0;
                n_clr_addr  = r_clr_addr + PAGE_W'(1);
                if (r_clr_addr == PAGE_W'(PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_page = in_page;
                    if (s_axis_tuser[0] == CMD_EPOCH) begin
                        n_before  = r_count;
                        n_evicted = '0;
                        n_state   = S_EV;
                    end else if (in_range) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (!r_dirty_rd) begin
                    // clean page: mark dirty and append at the newest end
                    page_we     = 1'b1;
                    page_waddr  = r_page;
                    page_wdirty = 1'b1;
                    page_wolder = r_newest;
                    if (r_count == '0) begin
                        n_oldest = r_page;
                    end else begin
                        newer_we    = 1'b1;
                        newer_waddr = r_newest;
                        newer_wdata = r_page;
                    end
                    n_newest = r_page;
                    n_count  = r_count + CNT_W'(1);
                    n_state  = S_IDLE;
                end else if (r_page == r_newest) begin
                    n_state = S_IDLE;
                end else begin
                    // unlink the dirty page from its neighbors
                    if (r_page == r_oldest) begin
                        n_oldest = r_newer_rd;
                    end else begin
                        newer_we    = 1'b1;
                        newer_waddr = r_older_rd;
                        newer_wdata = r_newer_rd;
                    end
                    // the newer neighbor is dirty, its flag stays set
                    page_we     = 1'b1;
                    page_waddr  = r_newer_rd;
                    page_wdirty = 1'b1;
                    page_wolder = r_older_rd;
                    n_state     = S_MOVE;
                end
            end
            S_MOVE: begin
                // relink at the newest end
                page_we     = 1'b1;
                page_waddr  = r_page;
                page_wdirty = 1'b1;
                page_wolder = r_newest;
                newer_we    = 1'b1;
                newer_waddr = r_newest;
                newer_wdata = r_page;
                n_newest    = r_page;
                n_state     = S_IDLE;
            end
            S_EV: begin
                if (over_target) begin
                    // r_newer_rd holds the link of the current oldest page
                    page_we     = 1'b1;
                    page_waddr  = r_oldest;
                    page_wdirty = 1'b0;
                    n_count     = count_dec;
                    n_evicted   = r_evicted + CNT_W'(1);
                    if (r_count != CNT_W'(1)) begin
                        n_oldest    = r_newer_rd;
                        newer_raddr = r_newer_rd;
                    end else begin
                        newer_raddr = r_oldest;
                    end
                end else begin
                    newer_raddr = r_oldest;
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_o_before  = FIELD_W'(r_before);
                        n_o_evicted = FIELD_W'(r_evicted);
                        n_o_after   = FIELD_W'(r_count);
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_target    <= TARGET_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            r_count     <= n_count;
            r_target    <= n_target;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page      <= n_page;
        r_before    <= n_before;
        r_evicted   <= n_evicted;
        r_o_before  <= n_o_before;
        r_o_evicted <= n_o_evicted;
        r_o_after   <= n_o_after;
    end

    // checks
    `LDS_ASSERT_ALWAYS(a_count_bound, CMP_W'(r_count) <= CMP_W'(PAGES), "count above store size")
    `LDS_ASSERT_NEXT(a_evict_step, evict_now, r_count == $past(count_dec), "count not decremented")
    `LDS_ASSERT_ALWAYS(a_result_sum, !r_out_valid || (r_o_before == o_sum), "report sums disagree")

endmodule

@@ tb/lru_dirty_set_limiter_top_tb.sv @@
// self-checking testbench for lru_dirty_set_limiter_top: directed table, fill pass, random phases
// depends on lds_pkg and the rtl only; an internal recency model predicts the untyped epoch reports
module lru_dirty_set_limiter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lds_pkg::*;

    localparam int QUIET_LIMIT   = 60000;  // longer than the clearing pass
    localparam int SETTLE_CYCLES = 8;      // longer than a write access
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 170;
    localparam int FILL_ITEMS    = 256;
    localparam int POOL_SIZE     = 40;
    localparam int MAX_REPORTED  = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] dirty_after;
        logic [FIELD_W-1:0] evicted_count;
        logic [FIELD_W-1:0] dirty_before;
    } t_epoch_report;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_TARGET
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic                    cmd;
        logic [PAGE_FIELD_W-1:0] page;
        logic [FIELD_W-1:0]      target;
        logic                    typed;   // report below is the expectation
        t_epoch_report           report;
    } t_plan_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [13:0] page, rest zero
    logic [0:0]            s_axis_tuser  = '0;   // [0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [14:0] dirty_before, [29:15] evicted_count,
                                                 // [44:30] dirty_after
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lru_dirty_set_limiter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // recency model: dirty flags plus the dirty pages ordered oldest first
    bit                  page_dirty [PAGES];
    logic [PAGE_W-1:0]   lru_order [$];
    logic [FIELD_W-1:0]  target_limit = TARGET_RESET;

    t_epoch_report       pending_reports [$];
    int unsigned         mismatch_count = 0;
    bit                  idle_on = 1'b1;     // both sides draw gaps while set

    // directed rows: expectations typed only where they are obvious
    t_plan_row directed_plan [25] = '{
        '{ROW_ITEM,   CMD_EPOCH, 14'd0,     15'd0,     1'b1, '{15'd0, 15'd0, 15'd0}}, // empty store
        '{ROW_ITEM,   CMD_WRITE, 14'd0,     15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_WRITE, 14'h3FFF,  15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_WRITE, 14'd0,     15'd0,     1'b0, '0},  // dirty page moves to newest
        '{ROW_ITEM,   CMD_WRITE, 14'd0,     15'd0,     1'b0, '0},  // rewrite of the newest page
        '{ROW_ITEM,   CMD_EPOCH, 14'h3FFF,  15'd0,     1'b1, '{15'd2, 15'd0, 15'd2}}, // page ignored
        '{ROW_TARGET, CMD_WRITE, 14'd0,     15'd1,     1'b0, '0},
        '{ROW_ITEM,   CMD_EPOCH, 14'd0,     15'd0,     1'b0, '0},  // oldest must be 16383
        '{ROW_ITEM,   CMD_WRITE, 14'd5,     15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_WRITE, 14'd6,     15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_WRITE, 14'd7,     15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_WRITE, 14'd5,     15'd0,     1'b0, '0},  // move from the middle
        '{ROW_ITEM,   CMD_WRITE, 14'd0,     15'd0,     1'b0, '0},  // move the oldest
        '{ROW_ITEM,   CMD_WRITE, 14'd7,     15'd0,     1'b0, '0},
        '{ROW_TARGET, CMD_WRITE, 14'd0,     15'd2,     1'b0, '0},
        '{ROW_ITEM,   CMD_EPOCH, 14'd0,     15'd0,     1'b0, '0},
        '{ROW_TARGET, CMD_WRITE, 14'd0,     15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_EPOCH, 14'd0,     15'd0,     1'b0, '0},  // evict everything
        '{ROW_ITEM,   CMD_EPOCH, 14'd0,     15'd0,     1'b1, '{15'd0, 15'd0, 15'd0}},
        '{ROW_TARGET, CMD_WRITE, 14'd0,     15'h7FFF,  1'b0, '0},  // target above range
        '{ROW_ITEM,   CMD_WRITE, 14'd1234,  15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_WRITE, 14'h1FFF,  15'd0,     1'b0, '0},
        '{ROW_ITEM,   CMD_EPOCH, 14'd0,     15'd0,     1'b1, '{15'd2, 15'd0, 15'd2}},
        '{ROW_TARGET, CMD_WRITE, 14'd0,     15'd2,     1'b0, '0},
        '{ROW_ITEM,   CMD_EPOCH, 14'd0,     15'd0,     1'b1, '{15'd2, 15'd0, 15'd2}}  // equal
    };

    task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] want,
                                 input logic [FIELD_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // applies one input item to the recency model; returns 1 when it yields a report
    function automatic bit advance_dirty_set(input logic cmd, input logic [PAGE_FIELD_W-1:0] page,
                                             output t_epoch_report report);
        int                idx [$];
        int unsigned       before_n;
        int unsigned       evicted_n;
        logic [PAGE_W-1:0] victim;
        report = '0;
        if (cmd == CMD_WRITE) begin
            if (int'(page) < PAGES) begin
                if (page_dirty[page]) begin
                    idx = lru_order.find_first_index with (item == PAGE_W'(page));
                    lru_order.delete(idx[0]);
                end else begin
                    page_dirty[page] = 1'b1;
                end
                lru_order.insert(lru_order.size(), PAGE_W'(page));
            end
            return 1'b0;
        end
        before_n  = lru_order.size();
        evicted_n = 0;
        while (lru_order.size() > int'(target_limit)) begin
            victim = lru_order[0];
            lru_order.delete(0);
            page_dirty[victim] = 1'b0;
            evicted_n++;
        end
        report.dirty_before  = FIELD_W'(before_n);
        report.evicted_count = FIELD_W'(evicted_n);
        report.dirty_after   = FIELD_W'(lru_order.size());
        return 1'b1;
    endfunction

    // one input transfer; entered and left right after a rising edge
    task automatic offer_item(input logic cmd, input logic [PAGE_FIELD_W-1:0] page,
                              input logic typed, input t_epoch_report typed_report);
        int unsigned   gap;
        t_epoch_report report;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-PAGE_FIELD_W){1'b0}}, page};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (advance_dirty_set(cmd, page, report))
            pending_reports.insert(pending_reports.size(), typed ? typed_report : report);
    endtask

    // sender pauses until every report is in and a pending write access has finished
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the target register, then read it back in the next transfer
    task automatic program_target(input logic [FIELD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TARGET;
        pwdata  <= ($urandom() & ~32'h7FFF) | APB_DATA_W'(value);  // upper bits are dropped
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        target_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[FIELD_W-1:0] !== value)
            flag_mismatch("target readback", value, prdata[FIELD_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stalls, two long hold-offs that back the block up into its input
    initial begin : report_sink
        int unsigned   gap;
        int unsigned   seen;
        t_epoch_report got;
        t_epoch_report want;
        seen = 0;
        @(posedge i_clk);
        forever begin
            if (seen == 40 || seen == 150)
                gap = LONG_HOLD;
            else
                gap = idle_on ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            seen++;
            got = t_epoch_report'(m_axis_tdata[3*FIELD_W-1:0]);
            if (pending_reports.size() == 0) begin
                flag_mismatch("report with none pending, dirty_before", '0, got.dirty_before);
            end else begin
                want = pending_reports[0];
                pending_reports.delete(0);
                if (got.dirty_before !== want.dirty_before)
                    flag_mismatch("dirty_before", want.dirty_before, got.dirty_before);
                if (got.evicted_count !== want.evicted_count)
                    flag_mismatch("evicted_count", want.evicted_count, got.evicted_count);
                if (got.dirty_after !== want.dirty_after)
                    flag_mismatch("dirty_after", want.dirty_after, got.dirty_after);
            end
        end
    end

    // ends the run once nothing has moved on any port for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [PAGE_FIELD_W-1:0] pool [POOL_SIZE];
        logic [PAGE_FIELD_W-1:0] page;
        logic [FIELD_W-1:0]      next_target;
        logic                    cmd;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part; the first transfer waits out the clearing pass
        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_TARGET) begin
                settle_idle();
                program_target(directed_plan[r].target);
            end else begin
                offer_item(directed_plan[r].cmd, directed_plan[r].page,
                           directed_plan[r].typed, directed_plan[r].report);
            end
        end

        // fill part of the store in scrambled order, then empty it in one epoch
        settle_idle();
        program_target(FIELD_W'(PAGES));
        for (int i = 0; i < FILL_ITEMS; i++)
            offer_item(CMD_WRITE, PAGE_FIELD_W'(i * 7919), 1'b0, '0);
        offer_item(CMD_EPOCH, '0, 1'b0, '0);
        settle_idle();
        program_target('0);
        offer_item(CMD_EPOCH, '0, 1'b0, '0);

        // random phases: a small page pool per phase so rewrites and evictions interleave
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_idle();
            unique case (ph % 5)
                0:       next_target = FIELD_W'($urandom_range(0, 24));
                1:       next_target = FIELD_W'($urandom_range(0, 1));
                2:       next_target = (ph % 2 == 0) ? FIELD_W'(16384) : 15'h7FFF;
                3:       next_target = FIELD_W'($urandom_range(0, 32767));
                default: next_target = FIELD_W'($urandom_range(2, 60));
            endcase
            program_target(next_target);
            idle_on = (ph % 3 != 2);
            foreach (pool[k])
                pool[k] = PAGE_FIELD_W'($urandom());
            pool[0] = '0;
            pool[1] = '1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = ($urandom_range(0, 7) == 0) ? CMD_EPOCH : CMD_WRITE;
                if (cmd == CMD_EPOCH || $urandom_range(0, 99) < 15)
                    page = PAGE_FIELD_W'($urandom());
                else
                    page = pool[$urandom_range(0, POOL_SIZE - 1)];
                offer_item(cmd, page, 1'b0, '0);
            end
            offer_item(CMD_EPOCH, PAGE_FIELD_W'($urandom()), 1'b0, '0);
        end

        idle_on = 1'b1;
        settle_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
